>>> rtl/rss_pkg.sv
package rss_pkg;

  localparam int CNT_W   = 16;
  localparam int SUM_W   = CNT_W + 8;
  localparam int SQ_W    = CNT_W + 15;
  localparam int NUM_W   = CNT_W + SQ_W + 1;
  localparam int OPND_W  = 32;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int STEP_W  = 5;

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [STEP_W-1:0] MEAN_LAST = STEP_W'(15);
  localparam logic [STEP_W-1:0] VAR_LAST  = STEP_W'(31);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(15);
  localparam logic [OPND_W-1:0] SQRT_ONE  = OPND_W'(1) << (OPND_W - 2);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SQ   = 10'b0000000010,
    ST_ACC  = 10'b0000000100,
    ST_MUL1 = 10'b0000001000,
    ST_MUL2 = 10'b0000010000,
    ST_MUL3 = 10'b0000100000,
    ST_DIVM = 10'b0001000000,
    ST_DIVV = 10'b0010000000,
    ST_SQRT = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    OP_DIV  = 2'b01,
    OP_SQRT = 2'b10
  } iter_op_t;

  typedef struct packed {
    logic              start;
    iter_op_t          op;
    logic [STEP_W-1:0] last;
  } iter_req_t;

endpackage

>>> rtl/rss_iter.sv
module rss_iter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rss_pkg::iter_req_t         req,
  input  logic [rss_pkg::OPND_W-1:0] ld_hi,
  input  logic [rss_pkg::OPND_W-1:0] ld_lo,
  input  logic [rss_pkg::OPND_W-1:0] ld_dv,
  output logic                       done,
  output logic [rss_pkg::OPND_W-1:0] res
);
  import rss_pkg::*;

  iter_op_t          op_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [OPND_W-1:0] rem_r, rem_nxt;
  logic [OPND_W-1:0] lo_r, lo_nxt;
  logic [OPND_W-1:0] dv_r, dv_nxt;

  logic [OPND_W:0]   sq_b;
  logic [OPND_W+1:0] opa, opb, diff;
  logic              ge;

  always_comb begin
    sq_b = {1'b0, lo_r} + {1'b0, dv_r};
    case (op_r)
      OP_DIV: begin
        opa = {1'b0, rem_r, lo_r[OPND_W-1]};
        opb = {2'b00, dv_r};
      end
      OP_SQRT: begin
        opa = {2'b00, rem_r};
        opb = {1'b0, sq_b};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    diff = opa - opb;
    ge   = ~diff[OPND_W+1];
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    dv_nxt   = dv_r;
    if (req.start) begin
      cnt_nxt  = req.last;
      busy_nxt = 1'b1;
      rem_nxt  = ld_hi;
      lo_nxt   = ld_lo;
      dv_nxt   = ld_dv;
    end else if (busy_r) begin
      case (op_r)
        OP_DIV: begin
          rem_nxt = ge ? diff[OPND_W-1:0] : opa[OPND_W-1:0];
          lo_nxt  = {lo_r[OPND_W-2:0], ge};
        end
        OP_SQRT: begin
          rem_nxt = ge ? diff[OPND_W-1:0] : rem_r;
          lo_nxt  = ge ? OPND_W'((lo_r >> 1) + dv_r) : (lo_r >> 1);
          dv_nxt  = dv_r >> 2;
        end
        default: begin
          rem_nxt = rem_r;
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (req.start) op_r <= req.op;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign res  = lo_r;

endmodule

>>> rtl/running_sample_statistics_unit.sv
// A new request is taken only once the previous result is in the output register. A zero
// count skips the MUL1-MUL3 products of the shared 32x32 multiplier and the steps of the
// shared bit-serial divide/square-root unit (16 mean, 32 variance and 16 root steps).
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low at a clock edge) clears count, min, max, sums and all handshake state.
module running_sample_statistics_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [7:0] in_rssi_dbm,
  input  logic        in_link_up,
  input  logic        in_clear_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sample_count,
  output logic signed [7:0] out_min_dbm,
  output logic signed [7:0] out_max_dbm,
  output logic signed [15:0] out_mean_q8,
  output logic [21:0] out_variance_q8,
  output logic [14:0] out_stddev_q8,
  output logic        out_full_res
);
  import rss_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [7:0]       min_r, min_nxt;
  logic signed [7:0]       max_r, max_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sumsq_r, sumsq_nxt;
  logic signed [7:0]       x_r;
  logic                    acc_r, full_r;
  logic [PROD_W-1:0]       prod_r;
  logic [NUM_W-1:0]        p1_r, num_r;
  logic [15:0]             mean_r;
  logic [21:0]             var_r;
  logic [14:0]             sd_r;

  logic                    out_valid_r;
  logic [15:0]             o_cnt_r;
  logic signed [7:0]       o_min_r, o_max_r;
  logic [15:0]             o_mean_r;
  logic [21:0]             o_var_r;
  logic [14:0]             o_sd_r;
  logic                    o_full_r;

  logic                    accept, load_out, full_c;
  logic [CNT_W-1:0]        cnt_c;
  logic signed [7:0]       min_c, max_c;
  logic signed [SUM_W-1:0] sum_c;
  logic [SQ_W-1:0]         sumsq_c;
  logic [SUM_W-1:0]        mag;
  logic [7:0]              x_mag;
  logic [OPND_W-1:0]       mul_a, mul_b, mean_dvd;
  logic [PROD_W-1:0]       prod_nxt;

  iter_req_t               ireq;
  logic [OPND_W-1:0]       ld_hi, ld_lo, ld_dv, ires;
  logic                    idone;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign x_mag    = x_r[7] ? 8'(-x_r) : 8'(x_r);
  assign mean_dvd = OPND_W'(mag) << 8;

  always_comb begin
    cnt_c   = in_clear_first ? '0 : count_r;
    min_c   = in_clear_first ? '0 : min_r;
    max_c   = in_clear_first ? '0 : max_r;
    sum_c   = in_clear_first ? '0 : sum_r;
    sumsq_c = in_clear_first ? '0 : sumsq_r;
    full_c  = in_link_up && (cnt_c == CNT_MAX);
    count_nxt = cnt_c;
    min_nxt   = min_c;
    max_nxt   = max_c;
    sum_nxt   = sum_c;
    sumsq_nxt = sumsq_c;
    if (in_link_up && !full_c) begin
      count_nxt = cnt_c + CNT_W'(1);
      sum_nxt   = sum_c + SUM_W'(in_rssi_dbm);
      if (cnt_c == '0) begin
        min_nxt = in_rssi_dbm;
        max_nxt = in_rssi_dbm;
      end else begin
        if (in_rssi_dbm < min_c) min_nxt = in_rssi_dbm;
        if (in_rssi_dbm > max_c) max_nxt = in_rssi_dbm;
      end
    end
  end

  always_comb begin
    case (state_r)
      ST_SQ: begin
        mul_a = OPND_W'(x_mag);
        mul_b = OPND_W'(x_mag);
      end
      ST_MUL1: begin
        mul_a = OPND_W'(count_r);
        mul_b = OPND_W'(sumsq_r);
      end
      ST_MUL2: begin
        mul_a = OPND_W'(mag);
        mul_b = OPND_W'(mag);
      end
      ST_MUL3: begin
        mul_a = OPND_W'(count_r);
        mul_b = OPND_W'(count_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    ireq.start = 1'b0;
    ireq.op    = OP_DIV;
    ireq.last  = MEAN_LAST;
    ld_hi      = '0;
    ld_lo      = '0;
    ld_dv      = '0;
    case (state_r)
      ST_MUL3: begin
        ireq.start = 1'b1;
        ld_hi      = {16'b0, mean_dvd[31:16]};
        ld_lo      = {mean_dvd[15:0], 16'b0};
        ld_dv      = OPND_W'(count_r);
      end
      ST_DIVM: begin
        ireq.start = idone;
        ireq.last  = VAR_LAST;
        ld_hi      = num_r[NUM_W-1:16];
        ld_lo      = {num_r[15:0], 16'b0};
        ld_dv      = prod_r[OPND_W-1:0];
      end
      ST_DIVV: begin
        ireq.start = idone;
        ireq.op    = OP_SQRT;
        ireq.last  = SQRT_LAST;
        ld_hi      = ires;
        ld_dv      = SQRT_ONE;
      end
      default: begin
        ireq.start = 1'b0;
      end
    endcase
  end

  rss_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ireq),
    .ld_hi (ld_hi),
    .ld_lo (ld_lo),
    .ld_dv (ld_dv),
    .done  (idone),
    .res   (ires)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (count_r == '0) ? ST_DONE : ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_DIVM;
      ST_DIVM: if (idone) state_nxt = ST_DIVV;
      ST_DIVV: if (idone) state_nxt = ST_SQRT;
      ST_SQRT: if (idone) state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= count_nxt;
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        sum_r   <= sum_nxt;
        sumsq_r <= sumsq_nxt;
      end else if (state_r == ST_ACC && acc_r) begin
        sumsq_r <= sumsq_r + SQ_W'(prod_r[15:0]);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_rssi_dbm;
      acc_r  <= in_link_up && !full_c;
      full_r <= full_c;
      mean_r <= '0;
      var_r  <= '0;
      sd_r   <= '0;
    end
    if (state_r == ST_SQ || state_r == ST_MUL1 || state_r == ST_MUL2 ||
        state_r == ST_MUL3) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_MUL2) p1_r <= NUM_W'(prod_r);
    if (state_r == ST_MUL3) num_r <= p1_r - NUM_W'(prod_r);
    if (state_r == ST_DIVM && idone) begin
      mean_r <= sum_r[SUM_W-1] ? 16'(16'd0 - ires[15:0]) : ires[15:0];
    end
    if (state_r == ST_DIVV && idone) var_r <= ires[29:8];
    if (state_r == ST_SQRT && idone) sd_r <= ires[14:0];
    if (load_out) begin
      o_cnt_r  <= 16'(count_r);
      o_min_r  <= min_r;
      o_max_r  <= max_r;
      o_mean_r <= mean_r;
      o_var_r  <= var_r;
      o_sd_r   <= sd_r;
      o_full_r <= full_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_count = o_cnt_r;
  assign out_min_dbm      = o_min_r;
  assign out_max_dbm      = o_max_r;
  assign out_mean_q8      = o_mean_r;
  assign out_variance_q8  = o_var_r;
  assign out_stddev_q8    = o_sd_r;
  assign out_full_res     = o_full_r;

endmodule
